[hw/rtl/tlf_pkg.sv]
package tlf_pkg;

   localparam int unsigned COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_BSLASH = 8'h5C;
   localparam logic [7:0] BYTE_FE     = 8'hFE;
   localparam logic [7:0] BYTE_FF     = 8'hFF;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_TRUNC = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
   } result_type;

   // One queue entry holds the results that one input transaction causes.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

endpackage

[hw/rtl/tlf_if.sv]
interface tlf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_end;

   modport source (output valid, output in_byte, output is_end, input ready);
   modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface tlf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_char;

   modport source (output valid, output kind, output out_char, input ready);
   modport sink   (input valid, input kind, input out_char, output ready);
endinterface

[hw/rtl/tlf_front.sv]
module tlf_front (
   input  logic                         clock,
   input  logic                         reset,
   tlf_req_if.sink                      req_ch,
   input  logic                         csr_we,
   input  logic [tlf_pkg::COUNT_W-1:0]  csr_wdata,
   input  logic                         queue_full,
   output logic                         push,
   output tlf_pkg::entry_type           push_data
);

   logic                        expect_bom_ff, expect_bom_in;
   logic                        saw_ff_ff, saw_ff_in;
   logic                        wide_mode_ff, wide_mode_in;
   logic                        wide_phase_ff, wide_phase_in;
   logic                        escape_pending_ff, escape_pending_in;
   logic [tlf_pkg::COUNT_W-1:0] line_count_ff, line_count_in;
   logic [tlf_pkg::COUNT_W-1:0] line_limit_ff;

   logic                        accept;
   logic                        skip;
   logic [tlf_pkg::COUNT_W-1:0] count_plus1;
   logic [tlf_pkg::COUNT_W-1:0] count_plus2;
   logic                        over_now;
   logic                        over_after_bslash;
   logic [7:0]                  b;

   function automatic logic [tlf_pkg::COUNT_W-1:0] sat_inc(
      input logic [tlf_pkg::COUNT_W-1:0] v);
      sat_inc = (v == tlf_pkg::COUNT_MAX) ? v : v + 1'b1;
   endfunction

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign b            = req_ch.in_byte;

   assign count_plus1       = sat_inc(line_count_ff);
   assign count_plus2       = sat_inc(count_plus1);
   assign over_now          = (line_limit_ff != '0) && (line_count_ff >= line_limit_ff);
   assign over_after_bslash = (line_limit_ff != '0) && (count_plus1 >= line_limit_ff);

   always_comb begin
      expect_bom_in     = expect_bom_ff;
      saw_ff_in         = saw_ff_ff;
      wide_mode_in      = wide_mode_ff;
      wide_phase_in     = wide_phase_ff;
      escape_pending_in = escape_pending_ff;
      line_count_in     = line_count_ff;
      skip              = 1'b0;
      push              = 1'b0;
      push_data.two           = 1'b0;
      push_data.first.kind    = tlf_pkg::KIND_CHAR;
      push_data.first.ch      = 8'h00;
      push_data.second.kind   = tlf_pkg::KIND_END;
      push_data.second.ch     = 8'h00;

      if (accept) begin
         if (req_ch.is_end) begin
            push          = 1'b1;
            push_data.two = (line_count_ff != '0);
            push_data.first.kind = (line_count_ff != '0) ? tlf_pkg::KIND_LINE
                                                         : tlf_pkg::KIND_END;
            expect_bom_in     = 1'b1;
            saw_ff_in         = 1'b0;
            wide_mode_in      = 1'b0;
            wide_phase_in     = 1'b1;
            escape_pending_in = 1'b0;
            line_count_in     = '0;
         end else begin
            // Byte-order-mark detection on the first two bytes of a stream.
            if (saw_ff_ff) begin
               saw_ff_in = 1'b0;
               if (b == tlf_pkg::BYTE_FE) begin
                  wide_mode_in = 1'b1;
                  skip         = 1'b1;
               end
            end else if (expect_bom_ff) begin
               expect_bom_in = 1'b0;
               if (b == tlf_pkg::BYTE_FF) begin
                  saw_ff_in = 1'b1;
                  skip      = 1'b1;
               end
            end

            // In wide mode only the first byte of each pair is kept.
            if (!skip && wide_mode_ff) begin
               wide_phase_in = !wide_phase_ff;
               if (!wide_phase_ff) begin
                  skip = 1'b1;
               end
            end

            if (!skip) begin
               if (escape_pending_ff) begin
                  escape_pending_in = 1'b0;
                  if (b == tlf_pkg::BYTE_LF) begin
                     push                 = 1'b1;
                     push_data.first.kind = tlf_pkg::KIND_LINE;
                     line_count_in        = '0;
                  end else if (b != tlf_pkg::BYTE_CR) begin
                     push                 = 1'b1;
                     push_data.two        = 1'b1;
                     push_data.first.kind = tlf_pkg::KIND_CHAR;
                     push_data.first.ch   = tlf_pkg::BYTE_BSLASH;
                     if (over_after_bslash) begin
                        push_data.second.kind = tlf_pkg::KIND_TRUNC;
                        line_count_in         = '0;
                     end else begin
                        push_data.second.kind = tlf_pkg::KIND_CHAR;
                        push_data.second.ch   = b;
                        line_count_in         = count_plus2;
                     end
                  end
               end else if (b == tlf_pkg::BYTE_LF) begin
                  push                 = 1'b1;
                  push_data.first.kind = tlf_pkg::KIND_LINE;
                  line_count_in        = '0;
               end else if (b == tlf_pkg::BYTE_BSLASH) begin
                  escape_pending_in = 1'b1;
               end else if (b != tlf_pkg::BYTE_NUL && b != tlf_pkg::BYTE_CR) begin
                  push = 1'b1;
                  if (over_now) begin
                     push_data.first.kind = tlf_pkg::KIND_TRUNC;
                     line_count_in        = '0;
                  end else begin
                     push_data.first.kind = tlf_pkg::KIND_CHAR;
                     push_data.first.ch   = b;
                     line_count_in        = count_plus1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_bom_ff     <= 1'b1;
         saw_ff_ff         <= 1'b0;
         wide_mode_ff      <= 1'b0;
         wide_phase_ff     <= 1'b1;
         escape_pending_ff <= 1'b0;
         line_count_ff     <= '0;
         line_limit_ff     <= '0;
      end else begin
         expect_bom_ff     <= expect_bom_in;
         saw_ff_ff         <= saw_ff_in;
         wide_mode_ff      <= wide_mode_in;
         wide_phase_ff     <= wide_phase_in;
         escape_pending_ff <= escape_pending_in;
         line_count_ff     <= line_count_in;
         if (csr_we) begin
            line_limit_ff <= csr_wdata;
         end
      end
   end

endmodule

[hw/rtl/tlf_queue.sv]
module tlf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tlf_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output tlf_pkg::entry_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tlf_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[hw/rtl/tlf_back.sv]
module tlf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  tlf_pkg::entry_type head,
   output logic               pop,
   tlf_rsp_if.source          rsp_ch
);

   logic                valid_ff, valid_in;
   logic                second_ff, second_in;
   tlf_pkg::result_type data_ff, data_in;
   logic                out_free;
   logic                load;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign load     = out_free && !empty;

   // The head entry leaves the queue with its last result.
   assign pop = load && (second_ff || !head.two);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      data_in   = data_ff;
      if (out_free) begin
         valid_in = !empty;
      end
      if (load) begin
         data_in   = second_ff ? head.second : head.first;
         second_in = !second_ff && head.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.kind     = data_ff.kind;
   assign rsp_ch.out_char = data_ff.ch;

endmodule

[hw/rtl/text_line_framer.sv]
// Text line framer: takes one byte or end marker per transaction on req_ch and
// gives characters, line ends, truncated line ends and an input end on rsp_ch.
// Input is accepted at one transaction per cycle while the queue has room.
// Most transactions cause zero or one result; an escaped byte other than CR
// or LF and an end marker after an open line cause two, sent in turn. A queue
// of QUEUE_DEPTH entries between the classifier and the output stage absorbs
// those pairs and short output stalls, so req_ch.ready drops only when that
// queue is full. The line limit is written through csr_we/csr_wdata while the
// block is idle, which the block does not enforce; zero disables it.
module text_line_framer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   tlf_req_if.sink                     req_ch,
   tlf_rsp_if.source                   rsp_ch,
   input  logic                        csr_we,
   input  logic [tlf_pkg::COUNT_W-1:0] csr_wdata
);

   logic               push;
   tlf_pkg::entry_type push_data;
   logic               queue_full;
   logic               queue_empty;
   tlf_pkg::entry_type head;
   logic               pop;

   tlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   tlf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   tlf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (queue_empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

[hw/rtl/tlf_checker.sv]
module tlf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_char
);

   // A result waiting on a stalled output keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_char))
      else $error("rsp transaction changed while stalled");

   // Only a character result carries a nonzero character.
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != tlf_pkg::KIND_CHAR |-> rsp_out_char == 8'h00)
      else $error("nonzero character on a non-character result");

   // Reset empties the output stage.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // The input side backs up only behind a loaded output stage.
   a_full_implies_out: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output stage");

endmodule

bind text_line_framer tlf_checker u_tlf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_out_char (rsp_ch.out_char)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SHOWN_ERRORS = 20;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [tlf_pkg::COUNT_W-1:0] csr_wdata;

   tlf_req_if req_bus ();
   tlf_rsp_if rsp_bus ();

   text_line_framer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Framing state as the block should hold it.
   logic bom_armed;
   logic ff_seen;
   logic wide_on;
   logic wide_odd;
   logic esc_wait;
   logic [tlf_pkg::COUNT_W-1:0] line_chars;
   logic [tlf_pkg::COUNT_W-1:0] limit_reg;

   tlf_pkg::result_type expected_results[$];

   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int long_stall_cycles = 0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int limits_used = 0;
   int cycles = 0;

   function automatic void clear_stream();
      bom_armed = 1'b1;
      ff_seen = 1'b0;
      wide_on = 1'b0;
      wide_odd = 1'b1;
      esc_wait = 1'b0;
      line_chars = '0;
   endfunction

   function automatic void push_result(input tlf_pkg::kind_type k, input logic [7:0] c);
      tlf_pkg::result_type r;
      r.kind = k;
      r.ch = c;
      expected_results.push_back(r);
   endfunction

   function automatic void count_char();
      if (line_chars != tlf_pkg::COUNT_MAX) line_chars++;
   endfunction

   function automatic logic at_limit();
      return limit_reg != '0 && line_chars >= limit_reg;
   endfunction

   // Works out the results of one accepted transaction.
   function automatic void frame_step(input logic [7:0] b, input logic end_mark);
      if (end_mark) begin
         if (line_chars != '0) push_result(tlf_pkg::KIND_LINE, 8'h00);
         push_result(tlf_pkg::KIND_END, 8'h00);
         clear_stream();
         return;
      end
      if (ff_seen) begin
         ff_seen = 1'b0;
         if (b == tlf_pkg::BYTE_FE) begin
            wide_on = 1'b1;
            return;
         end
      end else if (bom_armed) begin
         bom_armed = 1'b0;
         if (b == tlf_pkg::BYTE_FF) begin
            ff_seen = 1'b1;
            return;
         end
      end
      // In wide mode only the first byte of each pair survives.
      if (wide_on) begin
         wide_odd = ~wide_odd;
         if (wide_odd) return;
      end
      if (esc_wait) begin
         esc_wait = 1'b0;
         if (b == tlf_pkg::BYTE_CR) return;
         if (b == tlf_pkg::BYTE_LF) begin
            line_chars = '0;
            push_result(tlf_pkg::KIND_LINE, 8'h00);
            return;
         end
         // The backslash itself is stored without a limit check.
         push_result(tlf_pkg::KIND_CHAR, tlf_pkg::BYTE_BSLASH);
         count_char();
         if (at_limit()) begin
            line_chars = '0;
            push_result(tlf_pkg::KIND_TRUNC, 8'h00);
            return;
         end
         push_result(tlf_pkg::KIND_CHAR, b);
         count_char();
         return;
      end
      if (b == tlf_pkg::BYTE_NUL || b == tlf_pkg::BYTE_CR) return;
      if (b == tlf_pkg::BYTE_LF) begin
         line_chars = '0;
         push_result(tlf_pkg::KIND_LINE, 8'h00);
         return;
      end
      if (b == tlf_pkg::BYTE_BSLASH) begin
         esc_wait = 1'b1;
         return;
      end
      if (at_limit()) begin
         line_chars = '0;
         push_result(tlf_pkg::KIND_TRUNC, 8'h00);
         return;
      end
      push_result(tlf_pkg::KIND_CHAR, b);
      count_char();
   endfunction

   function automatic logic [7:0] text_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 8'($urandom_range(8'h20, 8'h7E));
      if (roll < 60) return tlf_pkg::BYTE_LF;
      if (roll < 65) return tlf_pkg::BYTE_CR;
      if (roll < 70) return tlf_pkg::BYTE_NUL;
      if (roll < 80) return tlf_pkg::BYTE_BSLASH;
      return 8'($urandom);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic end_mark);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.is_end <= end_mark;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      frame_step(b, end_mark);
      items_sent++;
   endtask

   task automatic send_end();
      send_item(8'($urandom), 1'b1);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // Dropped bytes cause no result, so give the pipeline time to settle.
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [tlf_pkg::COUNT_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      limit_reg = value;
      limits_used++;
      csr_we <= 1'b0;
   endtask

   task automatic test_plain_text();
      send_item("A", 1'b0);
      send_item(tlf_pkg::BYTE_NUL, 1'b0);
      send_item(tlf_pkg::BYTE_CR, 1'b0);
      send_item(tlf_pkg::BYTE_FF, 1'b0);
      send_item(tlf_pkg::BYTE_LF, 1'b0);
      send_item(tlf_pkg::BYTE_LF, 1'b0);
      send_item(tlf_pkg::BYTE_BSLASH, 1'b0);
      send_item("x", 1'b0);
      send_item(tlf_pkg::BYTE_BSLASH, 1'b0);
      send_item(tlf_pkg::BYTE_CR, 1'b0);
      send_item(tlf_pkg::BYTE_BSLASH, 1'b0);
      send_item(tlf_pkg::BYTE_LF, 1'b0);
      send_item(tlf_pkg::BYTE_BSLASH, 1'b0);
      send_item(tlf_pkg::BYTE_NUL, 1'b0);
      send_item("z", 1'b0);
      send_end();
   endtask

   task automatic test_byte_order_mark();
      send_item(tlf_pkg::BYTE_FF, 1'b0);
      send_item(tlf_pkg::BYTE_FE, 1'b0);
      send_item("h", 1'b0);
      send_item(tlf_pkg::BYTE_NUL, 1'b0);
      send_item(tlf_pkg::BYTE_BSLASH, 1'b0);
      send_item(tlf_pkg::BYTE_NUL, 1'b0);
      send_item("n", 1'b0);
      send_item(tlf_pkg::BYTE_NUL, 1'b0);
      send_end();
      send_item(tlf_pkg::BYTE_FF, 1'b0);
      send_item("q", 1'b0);
      send_end();
   endtask

   task automatic test_line_limit();
      drain_results();
      write_limit(17'd1);
      send_item("a", 1'b0);
      send_item("b", 1'b0);
      send_item(tlf_pkg::BYTE_BSLASH, 1'b0);
      send_item("c", 1'b0);
      send_item(tlf_pkg::BYTE_LF, 1'b0);
      send_end();
   endtask

   // The receiver holds off long enough for the block's queue to fill.
   task automatic test_backpressure();
      drain_results();
      write_limit(17'd0);
      sender_gaps = 1'b0;
      long_stall_cycles = 150;
      repeat (40) send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
      send_end();
      drain_results();
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_text();
      int roll;
      int sent;
      logic wide;
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: write_limit(17'd0);
            1: write_limit(17'd1);
            2: write_limit(17'd2);
            3: write_limit(17'($urandom_range(3, 12)));
            4: write_limit(17'd65536);
            default: write_limit(17'd5);
         endcase
         sender_gaps = (phase != 4) && (phase != 5);
         receiver_gaps = (phase != 3) && (phase != 5);
         sent = 0;
         wide = 1'b0;
         while (sent < 45) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               send_end();
               sent++;
               wide = 1'b0;
               roll = $urandom_range(0, 5);
               if (roll < 2) begin
                  send_item(tlf_pkg::BYTE_FF, 1'b0);
                  send_item(tlf_pkg::BYTE_FE, 1'b0);
                  wide = 1'b1;
               end else if (roll == 2) begin
                  send_item(tlf_pkg::BYTE_FF, 1'b0);
               end
            end else begin
               send_item(text_byte(), 1'b0);
               sent++;
               // Second byte of a wide pair, mostly zero as in real text.
               if (wide) send_item(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, 1'b0);
            end
         end
      end
   endtask

   always @(posedge clock) begin : receiver
      int rx_hold;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_hold = 0;
      end else begin
         if (long_stall_cycles != 0) begin
            rx_hold = long_stall_cycles;
            long_stall_cycles = 0;
         end else if (rx_hold == 0 && receiver_gaps && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 13);
         end
         if (rx_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            rx_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      tlf_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
               $display("%0t: unexpected result: expected none, actual kind %0d char %02h",
                        $time, rsp_bus.kind, rsp_bus.out_char);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.kind !== want.kind) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("%0t: kind mismatch: expected %0d, actual %0d",
                           $time, want.kind, rsp_bus.kind);
            end
            if (rsp_bus.out_char !== want.ch) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("%0t: out_char mismatch: expected %02h, actual %02h",
                           $time, want.ch, rsp_bus.out_char);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycles, expected_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.is_end = 1'b0;
      limit_reg = '0;
      clear_stream();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_plain_text();
      test_byte_order_mark();
      test_line_limit();
      test_backpressure();
      test_random_text();

      drain_results();
      repeat (24) @(posedge clock);
      $display("Sent %0d transactions and checked %0d results over %0d line limit writes,",
               items_sent, results_checked, limits_used);
      $display("covering wide mode, escapes, truncation, line limits and backpressure.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[text_line_framer.f]
hw/rtl/tlf_pkg.sv
hw/rtl/tlf_if.sv
hw/rtl/tlf_front.sv
hw/rtl/tlf_queue.sv
hw/rtl/tlf_back.sv
hw/rtl/text_line_framer.sv
hw/rtl/tlf_checker.sv
tb/tb_top.sv
